// ===== hdl/als_pkg.sv =====
// ----------------------------------------------------------------------------
// als_pkg
// Shared sizes, codes and helper functions of the arc length spline evaluator.
// ----------------------------------------------------------------------------
package als_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_AW       = $clog2(MAX_SEGMENTS + 1);
    localparam int KW           = $clog2(MAX_SEGMENTS);
    localparam int COEF_DEPTH   = 4 * MAX_SEGMENTS;
    localparam int COEF_AW      = $clog2(COEF_DEPTH);
    localparam int MUL_W        = 33;
    localparam int CORDIC_STEPS = 17;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [3:0] WSEL_START = 4'd0;
    localparam logic [3:0] WSEL_X_C0  = 4'd1;
    localparam logic [3:0] WSEL_X_C3  = 4'd4;
    localparam logic [3:0] WSEL_Y_C0  = 4'd5;
    localparam logic [3:0] WSEL_Y_C3  = 4'd8;

    localparam logic signed [17:0] HALF_PI_Q16 = 18'sd102944;
    localparam logic [30:0]        CURV_SAT    = 31'h7FFF_FFFF;

    // round(atan(2^-i) * 2^16)
    function automatic logic [16:0] cordic_angle(input logic [4:0] i);
        logic [16:0] a;
        case (i)
            5'd0:    a = 17'd51472;
            5'd1:    a = 17'd30385;
            5'd2:    a = 17'd16055;
            5'd3:    a = 17'd8150;
            5'd4:    a = 17'd4091;
            5'd5:    a = 17'd2047;
            5'd6:    a = 17'd1024;
            5'd7:    a = 17'd512;
            5'd8:    a = 17'd256;
            5'd9:    a = 17'd128;
            5'd10:   a = 17'd64;
            5'd11:   a = 17'd32;
            5'd12:   a = 17'd16;
            5'd13:   a = 17'd8;
            5'd14:   a = 17'd4;
            5'd15:   a = 17'd2;
            5'd16:   a = 17'd1;
            default: a = 17'd0;
        endcase
        return a;
    endfunction

    // clamp a wide signed value into Q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/als_ram.sv =====
// ----------------------------------------------------------------------------
// als_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module als_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/als_mul.sv =====
// ----------------------------------------------------------------------------
// als_mul
// Shared signed multiplier, one registered product per cycle.
// ----------------------------------------------------------------------------
module als_mul
    import als_pkg::*;
(
    input  logic                    aclk,
    input  logic signed [MUL_W-1:0] op_a,
    input  logic signed [MUL_W-1:0] op_b,
    output logic [63:0]             prod
);

    logic signed [2*MUL_W-1:0] full;
    logic [63:0]               prod_reg;

    assign full = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= full[63:0];
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/als_sqrt.sv =====
// ----------------------------------------------------------------------------
// als_sqrt
// Bit-serial integer square root of a 64 bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module als_sqrt
    import als_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] value,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign trial = root_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            rem_next  = value;
            root_next = '0;
            bit_next  = 64'd1 << 62;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign busy = busy_reg;
    assign root = root_reg[31:0];

endmodule

// ===== hdl/als_div.sv =====
// ----------------------------------------------------------------------------
// als_div
// Restoring divider, one quotient bit a cycle, quotient saturated to 31 bits.
// ----------------------------------------------------------------------------
module als_div
    import als_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [95:0] num,
    input  logic [95:0] den,
    output logic        busy,
    output logic [30:0] quot
);

    logic         busy_reg, busy_next;
    logic [95:0]  rem_reg, rem_next;
    logic [125:0] dsh_reg, dsh_next;
    logic [30:0]  q_reg, q_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic         fits;

    assign fits = dsh_reg <= {30'd0, rem_reg};

    always_comb begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            rem_next  = num;
            dsh_next  = {den, 30'd0};
            q_next    = '0;
            cnt_next  = 5'd30;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg[95:0];
            end
            q_next   = {q_reg[29:0], fits};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

// ===== hdl/als_cordic.sv =====
// ----------------------------------------------------------------------------
// als_cordic
// Vectoring CORDIC arctangent, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module als_cordic
    import als_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] dx,
    input  logic signed [31:0] dy,
    output logic               busy,
    output logic signed [17:0] angle
);

    logic               busy_reg, busy_next;
    logic signed [35:0] x_reg, x_next;
    logic signed [35:0] y_reg, y_next;
    logic signed [18:0] z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic signed [35:0] xs, ys, dx_w, dy_w;
    logic signed [18:0] ang, half_w;

    assign xs     = x_reg >>> i_reg;
    assign ys     = y_reg >>> i_reg;
    assign dx_w   = {{4{dx[31]}}, dx};
    assign dy_w   = {{4{dy[31]}}, dy};
    assign ang    = {2'b00, cordic_angle(i_reg)};
    assign half_w = {HALF_PI_Q16[17], HALF_PI_Q16};

    always_comb begin
        busy_next = busy_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        if (start) begin
            i_next = '0;
            if (dx == 32'sd0) begin
                // vertical tangent: answer directly
                if (dy > 32'sd0) begin
                    z_next = half_w;
                end else if (dy < 32'sd0) begin
                    z_next = -half_w;
                end else begin
                    z_next = '0;
                end
            end else begin
                busy_next = 1'b1;
                z_next    = '0;
                if (dx < 32'sd0) begin
                    x_next = -dx_w;
                    y_next = -dy_w;
                end else begin
                    x_next = dx_w;
                    y_next = dy_w;
                end
            end
        end else if (busy_reg) begin
            if (!y_reg[35]) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
            end else begin
                i_next = i_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

    // limit to plus or minus pi/2
    always_comb begin
        if (z_reg > half_w) begin
            angle = HALF_PI_Q16;
        end else if (z_reg < -half_w) begin
            angle = -HALF_PI_Q16;
        end else begin
            angle = z_reg[17:0];
        end
    end

    assign busy = busy_reg;

endmodule

// ===== hdl/arc_length_spline_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// arc_length_spline_evaluator_unit
// Path segment table and query engine: position, slope, heading, curvature.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata 80 b, s_tuser 1 b (cmd)
//  m_        out  m_tvalid/m_tready    m_tdata 184 b, m_tuser 2 b (flags)
//  cfg_      in   cfg_we               cfg_wdata 7 b (segments_in_use)
//
//  A table write goes straight from accept to the done state.
//  A query scans the start RAM one entry a cycle across n entries, n the
//  clamped segment count; the shared multiplier then runs 14 products,
//  the square root takes 32 steps and the divider 31.
//  aresetn is synchronous, active low; the table RAMs are not cleared.
//  A finished result waits in the output register; the next beat is taken
//  meanwhile, and the sequencer holds its result while m_tready is low.
// ----------------------------------------------------------------------------
module arc_length_spline_evaluator_unit
    import als_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [6:0] segment_index, [10:7] word_select, [42:11] write_value,
    // [74:43] arc_length, [79:75] zero
    input  logic [79:0]  s_tdata,
    // [0] cmd
    input  logic         s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] deriv_x, [127:96] deriv_y,
    // [145:128] heading, [176:146] curvature, [183:177] zero
    output logic [183:0] m_tdata,
    // [0] out_of_range, [1] degenerate
    output logic [1:0]   m_tuser
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_END    = 10'b00_0000_0010,
        ST_SEARCH = 10'b00_0000_0100,
        ST_DS     = 10'b00_0000_1000,
        ST_COEF   = 10'b00_0001_0000,
        ST_EVAL   = 10'b00_0010_0000,
        ST_SQRT   = 10'b00_0100_0000,
        ST_DMUL   = 10'b00_1000_0000,
        ST_DIV    = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    function automatic logic signed [51:0] sx32(input logic signed [31:0] v);
        return {{20{v[31]}}, v};
    endfunction

    function automatic logic signed [51:0] sx48(input logic signed [47:0] v);
        return {{4{v[47]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] mx(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    // input fields
    logic [6:0]         in_seg;
    logic [3:0]         in_sel;
    logic signed [31:0] in_wval, in_arc;
    logic               acc;

    assign in_seg  = s_tdata[6:0];
    assign in_sel  = s_tdata[10:7];
    assign in_wval = s_tdata[42:11];
    assign in_arc  = s_tdata[74:43];
    assign acc     = s_tvalid && s_tready;

    // registers
    state_t             state_reg, state_next;
    logic [6:0]         nseg_reg, nseg_next;
    logic               mval_reg, mval_next;
    logic [183:0]       mdata_reg, mdata_next;
    logic [1:0]         muser_reg, muser_next;
    logic               iswr_reg, iswr_next;
    logic               flag_reg, flag_next;
    logic               found_reg, found_next;
    logic               degen_reg, degen_next;
    logic signed [31:0] s_reg, s_next;
    logic signed [31:0] kst_reg, kst_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [SEG_AW-1:0]  cmp_reg, cmp_next;
    logic [SEG_AW-1:0]  n_reg, n_next;
    logic signed [31:0] ds_reg, ds_next;
    logic [2:0]         j_reg, j_next;
    logic [3:0]         step_reg, step_next;
    logic signed [31:0] cx_reg [4];
    logic signed [31:0] cx_next [4];
    logic signed [31:0] cy_reg [4];
    logic signed [31:0] cy_next [4];
    logic signed [47:0] p3x_reg, p3x_next, p3y_reg, p3y_next;
    logic signed [31:0] t1x_reg, t1x_next, t1y_reg, t1y_next;
    logic signed [31:0] t2x_reg, t2x_next, t2y_reg, t2y_next;
    logic signed [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [31:0] ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [63:0] p1_reg, p1_next;
    logic [63:0]        num_reg, num_next;
    logic [63:0]        sq_reg, sq_next;
    logic [63:0]        den_reg, den_next;
    logic [63:0]        dlo_reg, dlo_next;

    // clamped segment count
    logic [SEG_AW-1:0] n_eff;
    always_comb begin
        if (nseg_reg == 7'd0) begin
            n_eff = SEG_AW'(1);
        end else if (int'(nseg_reg) > MAX_SEGMENTS) begin
            n_eff = SEG_AW'(MAX_SEGMENTS);
        end else begin
            n_eff = nseg_reg[SEG_AW-1:0];
        end
    end

    // table RAMs
    logic               st_we, x_we, y_we;
    logic [SEG_AW-1:0]  st_raddr;
    logic [COEF_AW-1:0] c_waddr, c_raddr;
    logic [1:0]         c_off;
    logic signed [31:0] st_rd, x_rd, y_rd;

    always_comb begin
        st_we = 1'b0;
        x_we  = 1'b0;
        y_we  = 1'b0;
        if (acc && s_tuser == CMD_WRITE) begin
            if (in_sel == WSEL_START) begin
                st_we = int'(in_seg) <= MAX_SEGMENTS;
            end else if (int'(in_seg) < MAX_SEGMENTS) begin
                x_we = in_sel >= WSEL_X_C0 && in_sel <= WSEL_X_C3;
                y_we = in_sel >= WSEL_Y_C0 && in_sel <= WSEL_Y_C3;
            end
        end
    end

    assign c_off   = (in_sel <= WSEL_X_C3) ? 2'(in_sel - WSEL_X_C0) : 2'(in_sel - WSEL_Y_C0);
    assign c_waddr = {in_seg[KW-1:0], c_off};
    assign c_raddr = {k_reg, j_reg[1:0]};

    // start RAM address: end breakpoint first, then a rolling scan from 0
    always_comb begin
        case (state_reg)
            ST_END:    st_raddr = '0;
            ST_SEARCH: st_raddr = cmp_reg + SEG_AW'(1);
            default:   st_raddr = n_eff;
        endcase
    end

    als_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS + 1)) u_start_ram (
        .aclk (aclk),
        .we   (st_we),
        .waddr(in_seg[SEG_AW-1:0]),
        .wdata(in_wval),
        .raddr(st_raddr),
        .rdata(st_rd)
    );

    als_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_x_ram (
        .aclk (aclk),
        .we   (x_we),
        .waddr(c_waddr),
        .wdata(in_wval),
        .raddr(c_raddr),
        .rdata(x_rd)
    );

    als_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_y_ram (
        .aclk (aclk),
        .we   (y_we),
        .waddr(c_waddr),
        .wdata(in_wval),
        .raddr(c_raddr),
        .rdata(y_rd)
    );

    // shared multiplier operand select
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [63:0]             prod;
    logic signed [51:0]      prod_fl;
    logic [31:0]             sq_root;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_EVAL) begin
            case (step_reg)
                4'd0:    begin mul_a = mx(cx_reg[3]); mul_b = mx(ds_reg); end
                4'd1:    begin mul_a = mx(cy_reg[3]); mul_b = mx(ds_reg); end
                4'd2:    begin mul_a = mx(t1x_reg);   mul_b = mx(ds_reg); end
                4'd3:    begin mul_a = mx(t1y_reg);   mul_b = mx(ds_reg); end
                4'd4:    begin mul_a = mx(t2x_reg);   mul_b = mx(ds_reg); end
                4'd5:    begin mul_a = mx(t2y_reg);   mul_b = mx(ds_reg); end
                4'd6:    begin mul_a = mx(ax_reg);    mul_b = mx(ds_reg); end
                4'd7:    begin mul_a = mx(ay_reg);    mul_b = mx(ds_reg); end
                4'd9:    begin mul_a = mx(dx_reg);    mul_b = mx(ddy_reg); end
                4'd10:   begin mul_a = mx(ddx_reg);   mul_b = mx(dy_reg); end
                4'd11:   begin mul_a = mx(dx_reg);    mul_b = mx(dx_reg); end
                4'd12:   begin mul_a = mx(dy_reg);    mul_b = mx(dy_reg); end
                default: begin mul_a = '0;            mul_b = '0; end
            endcase
        end else if (state_reg == ST_DMUL) begin
            mul_b = {1'b0, sq_root};
            if (step_reg == 4'd0) begin
                mul_a = {1'b0, den_reg[31:0]};
            end else begin
                mul_a = {1'b0, den_reg[63:32]};
            end
        end
    end

    als_mul u_mul (
        .aclk(aclk),
        .op_a(mul_a),
        .op_b(mul_b),
        .prod(prod)
    );

    assign prod_fl = sx48(prod[63:16]);

    // iterative units
    logic        sqrt_start, sqrt_busy;
    logic [63:0] sqrt_in;
    logic        div_start, div_busy;
    logic [95:0] div_den;
    logic [30:0] div_q;
    logic        cord_start, cord_busy;
    logic signed [17:0] cord_z;

    assign sqrt_in = sq_reg + prod;
    assign div_den = {prod, 32'd0} + {32'd0, dlo_reg};

    als_sqrt u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sqrt_start),
        .value  (sqrt_in),
        .busy   (sqrt_busy),
        .root   (sq_root)
    );

    als_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    ({num_reg, 32'd0}),
        .den    (div_den),
        .busy   (div_busy),
        .quot   (div_q)
    );

    als_cordic u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cord_start),
        .dx     (dx_reg),
        .dy     (dy_reg),
        .busy   (cord_busy),
        .angle  (cord_z)
    );

    // polynomial helpers from a latched p3
    logic signed [51:0] p3x_w, p3y_w, c2x2, c2y2;
    assign p3x_w = sx48(p3x_reg);
    assign p3y_w = sx48(p3y_reg);
    assign c2x2  = sx32(cx_reg[2]) <<< 1;
    assign c2y2  = sx32(cy_reg[2]) <<< 1;

    logic out_free;
    assign out_free = !mval_reg || m_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        nseg_next  = nseg_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        iswr_next  = iswr_reg;
        flag_next  = flag_reg;
        found_next = found_reg;
        degen_next = degen_reg;
        s_next     = s_reg;
        kst_next   = kst_reg;
        k_next     = k_reg;
        cmp_next   = cmp_reg;
        n_next     = n_reg;
        ds_next    = ds_reg;
        j_next     = j_reg;
        step_next  = step_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        p3x_next   = p3x_reg;
        p3y_next   = p3y_reg;
        t1x_next   = t1x_reg;
        t1y_next   = t1y_reg;
        t2x_next   = t2x_reg;
        t2y_next   = t2y_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        ddx_next   = ddx_reg;
        ddy_next   = ddy_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        p1_next    = p1_reg;
        num_next   = num_reg;
        sq_next    = sq_reg;
        den_next   = den_reg;
        dlo_next   = dlo_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        cord_start = 1'b0;

        if (cfg_we) begin
            nseg_next = cfg_wdata;
        end
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    iswr_next  = s_tuser == CMD_WRITE;
                    flag_next  = 1'b0;
                    found_next = 1'b0;
                    degen_next = 1'b0;
                    s_next     = in_arc;
                    n_next     = n_eff;
                    state_next = (s_tuser == CMD_WRITE) ? ST_DONE : ST_END;
                end
            end
            ST_END: begin
                // clamp past the end breakpoint
                if (st_rd < s_reg) begin
                    s_next    = st_rd;
                    flag_next = 1'b1;
                end
                cmp_next   = '0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (cmp_reg == '0) begin
                    kst_next = st_rd;
                end
                if (st_rd <= s_reg) begin
                    found_next = 1'b1;
                    k_next     = cmp_reg[KW-1:0];
                    kst_next   = st_rd;
                end
                if (cmp_reg == n_reg - SEG_AW'(1)) begin
                    state_next = ST_DS;
                end else begin
                    cmp_next = cmp_reg + SEG_AW'(1);
                end
            end
            ST_DS: begin
                if (found_reg) begin
                    ds_next = sat32(sx32(s_reg) - sx32(kst_reg));
                end else begin
                    // below the first start: pin to segment 0 at its start
                    ds_next   = '0;
                    k_next    = '0;
                    flag_next = 1'b1;
                end
                j_next     = '0;
                state_next = ST_COEF;
            end
            ST_COEF: begin
                if (j_reg != 3'd0) begin
                    cx_next[2'(j_reg - 3'd1)] = x_rd;
                    cy_next[2'(j_reg - 3'd1)] = y_rd;
                end
                if (j_reg == 3'd4) begin
                    step_next  = '0;
                    state_next = ST_EVAL;
                end else begin
                    j_next = j_reg + 3'd1;
                end
            end
            ST_EVAL: begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    4'd1: begin
                        p3x_next = prod[63:16];
                        t1x_next = sat32(prod_fl + sx32(cx_reg[2]));
                    end
                    4'd2: begin
                        p3y_next = prod[63:16];
                        t1y_next = sat32(prod_fl + sx32(cy_reg[2]));
                        ax_next  = sat32((p3x_w <<< 1) + p3x_w + c2x2);
                        ddx_next = sat32((p3x_w <<< 2) + (p3x_w <<< 1) + c2x2);
                    end
                    4'd3: begin
                        t2x_next = sat32(prod_fl + sx32(cx_reg[1]));
                        ay_next  = sat32((p3y_w <<< 1) + p3y_w + c2y2);
                        ddy_next = sat32((p3y_w <<< 2) + (p3y_w <<< 1) + c2y2);
                    end
                    4'd4: t2y_next = sat32(prod_fl + sx32(cy_reg[1]));
                    4'd5: px_next  = sat32(prod_fl + sx32(cx_reg[0]));
                    4'd6: py_next  = sat32(prod_fl + sx32(cy_reg[0]));
                    4'd7: dx_next  = sat32(prod_fl + sx32(cx_reg[1]));
                    4'd8: dy_next  = sat32(prod_fl + sx32(cy_reg[1]));
                    4'd9: begin
                        if (dx_reg == 32'sd0 && dy_reg == 32'sd0) begin
                            degen_next = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            cord_start = 1'b1;
                        end
                    end
                    4'd10: p1_next = $signed(prod);
                    4'd11: begin
                        if (p1_reg >= $signed(prod)) begin
                            num_next = p1_reg - prod;
                        end else begin
                            num_next = prod - p1_reg;
                        end
                    end
                    4'd12: sq_next = prod;
                    4'd13: begin
                        den_next   = sqrt_in;
                        sqrt_start = 1'b1;
                        state_next = ST_SQRT;
                    end
                    default: ;
                endcase
            end
            ST_SQRT: begin
                if (!sqrt_busy) begin
                    step_next  = '0;
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd1) begin
                    dlo_next = prod;
                end else if (step_reg == 4'd2) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_busy && !cord_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register frees up
                if (out_free) begin
                    mval_next = 1'b1;
                    if (iswr_reg) begin
                        mdata_next = '0;
                        muser_next = '0;
                    end else begin
                        mdata_next = {7'd0,
                                      degen_reg ? CURV_SAT : div_q,
                                      degen_reg ? 18'sd0 : cord_z,
                                      dy_reg, dx_reg, py_reg, px_reg};
                        muser_next = {degen_reg, flag_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            nseg_reg  <= 7'd1;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            nseg_reg  <= nseg_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
        iswr_reg  <= iswr_next;
        flag_reg  <= flag_next;
        found_reg <= found_next;
        degen_reg <= degen_next;
        s_reg     <= s_next;
        kst_reg   <= kst_next;
        k_reg     <= k_next;
        cmp_reg   <= cmp_next;
        n_reg     <= n_next;
        ds_reg    <= ds_next;
        j_reg     <= j_next;
        step_reg  <= step_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        p3x_reg   <= p3x_next;
        p3y_reg   <= p3y_next;
        t1x_reg   <= t1x_next;
        t1y_reg   <= t1y_next;
        t2x_reg   <= t2x_next;
        t2y_reg   <= t2y_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        ddx_reg   <= ddx_next;
        ddy_reg   <= ddy_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        p1_reg    <= p1_next;
        num_reg   <= num_next;
        sq_reg    <= sq_next;
        den_reg   <= den_next;
        dlo_reg   <= dlo_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    // checks
    a_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_WRITE) |=> state_reg == ST_DONE)
        else $error("write beat did not go straight to result");

    a_degen_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[176:146] == CURV_SAT
                                      && m_tdata[145:128] == 18'd0))
        else $error("degenerate result without saturated curvature");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[145:128]) <= HALF_PI_Q16
                      && $signed(m_tdata[145:128]) >= -HALF_PI_Q16))
        else $error("heading outside half pi");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside done state");

endmodule

// ===== bench/tb_arc_length_spline_evaluator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arc_length_spline_evaluator_unit
// Loads the segment table, sweeps the segment count through its extremes and
// checks every result beat against a cycle-free model of the spline query
// (position, slope, CORDIC heading, curvature), with random stalls on both
// streams, a long output hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module tb_arc_length_spline_evaluator_unit;
    import als_pkg::*;

    localparam int  LIMIT_CYCLES = 600000;
    localparam int  HOLD_CYCLES  = 3000;
    localparam int  TAIL_CYCLES  = 200;
    localparam int  USED_SEGS    = 8;
    localparam longint Q_ONE     = 65536;

    typedef struct {
        logic        cmd;
        logic [6:0]  seg;
        logic [3:0]  wsel;
        logic [31:0] wval;
        logic [31:0] arc;
    } beat_t;

    typedef struct {
        logic [31:0] px, py, dx, dy;
        logic [17:0] head;
        logic [30:0] curv;
        logic        oor, degen;
    } answer_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_we = 1'b0;
    logic [6:0]    cfg_wdata = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [79:0]   s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [183:0]  m_tdata;
    logic [1:0]    m_tuser;

    beat_t   send_queue[$];
    answer_t answers_due[$];
    beat_t   on_bus;
    int      errors = 0;
    int      cycles = 0;
    bit      calm = 1'b0;
    logic    hold_go = 1'b0;
    int      hold_left = 0;

    // model state: table words and the segment count register
    longint  start_tab[0:MAX_SEGMENTS];
    longint  xcoef[0:4*MAX_SEGMENTS-1];
    longint  ycoef[0:4*MAX_SEGMENTS-1];
    int      seg_count = 1;

    arc_length_spline_evaluator_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------ model
    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, floored
    function automatic longint qprod(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic void spline_axis(input longint c0, c1, c2, c3, ds,
                                        output longint pos, d1, d2);
        longint p3, t, a;
        p3  = qprod(c3, ds);
        t   = sat32(p3 + c2);
        t   = sat32(qprod(t, ds) + c1);
        pos = sat32(qprod(t, ds) + c0);
        a   = sat32(3 * p3 + 2 * c2);
        d1  = sat32(qprod(a, ds) + c1);
        d2  = sat32(6 * p3 + 2 * c2);
    endfunction

    function automatic longint cordic_heading(longint dx, longint dy);
        longint x, y, z, xs, ys;
        x = dx;
        y = dy;
        z = 0;
        if (dx == 0) return dy > 0 ? 102944 : (dy < 0 ? -102944 : 0);
        if (x < 0) begin
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(cordic_angle(i[4:0]));
            end else begin
                x -= ys; y += xs; z -= longint'(cordic_angle(i[4:0]));
            end
        end
        if (z > 102944) z = 102944;
        if (z < -102944) z = -102944;
        return z;
    endfunction

    function automatic logic [30:0] curvature_mag(longint dx, dy, ddx, ddy);
        longint      p1, p2;
        logic [63:0] num, den, rem, root, bitv;
        logic [127:0] dr, wide_num;
        logic [30:0] q;
        p1  = dx * ddy;
        p2  = ddx * dy;
        num = (p1 >= p2) ? 64'(p1 - p2) : 64'(p2 - p1);
        den = 64'(dx * dx) + 64'(dy * dy);
        rem  = den;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        dr       = 128'(den) * 128'(root[31:0]);
        wide_num = {32'd0, num, 32'd0};
        q = '0;
        for (int b = 30; b >= 0; b--) begin
            if (dr * 128'(q | (31'd1 << b)) <= wide_num) q = q | (31'd1 << b);
        end
        return q;
    endfunction

    // apply one accepted beat to the model table and work out its answer
    function automatic answer_t spline_answer(beat_t it);
        answer_t r;
        longint  s, ds, px, py, dx, dy, ddx, ddy, v;
        int      n, k;
        r = '{default: '0};
        if (it.cmd == CMD_WRITE) begin
            v = longint'($signed(it.wval));
            if (it.wsel == WSEL_START) begin
                if (it.seg <= MAX_SEGMENTS) start_tab[it.seg] = v;
            end else if (it.wsel <= WSEL_Y_C3 && it.seg < MAX_SEGMENTS) begin
                if (it.wsel <= WSEL_X_C3) xcoef[it.seg*4 + (it.wsel - WSEL_X_C0)] = v;
                else                      ycoef[it.seg*4 + (it.wsel - WSEL_Y_C0)] = v;
            end
            return r;
        end
        n = seg_count < 1 ? 1 : (seg_count > MAX_SEGMENTS ? MAX_SEGMENTS : seg_count);
        s = longint'($signed(it.arc));
        if (s > start_tab[n]) begin
            s = start_tab[n];
            r.oor = 1'b1;
        end
        k = -1;
        for (int i = 0; i < n; i++) if (start_tab[i] <= s) k = i;
        if (k < 0) begin
            k = 0;
            s = start_tab[0];
            r.oor = 1'b1;
        end
        ds = sat32(s - start_tab[k]);
        spline_axis(xcoef[k*4], xcoef[k*4+1], xcoef[k*4+2], xcoef[k*4+3], ds, px, dx, ddx);
        spline_axis(ycoef[k*4], ycoef[k*4+1], ycoef[k*4+2], ycoef[k*4+3], ds, py, dy, ddy);
        r.px = px[31:0];
        r.py = py[31:0];
        r.dx = dx[31:0];
        r.dy = dy[31:0];
        if (dx == 0 && dy == 0) begin
            r.degen = 1'b1;
            r.curv  = CURV_SAT;
        end else begin
            v      = cordic_heading(dx, dy);
            r.head = v[17:0];
            r.curv = curvature_mag(dx, dy, ddx, ddy);
        end
        return r;
    endfunction

    // ----------------------------------------------------------- driver side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            // offer the next beat unless this cycle idles
            if (send_queue.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
                on_bus   <= send_queue[0];
                s_tuser  <= send_queue[0].cmd;
                s_tdata  <= {5'd0, send_queue[0].arc, send_queue[0].wval,
                             send_queue[0].wsel, send_queue[0].seg};
                s_tvalid <= 1'b1;
                void'(send_queue.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long hold-off of the result stream, counted here
    always @(posedge aclk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 1 || hold_go) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 31);
        end
    end

    // ---------------------------------------------------------- monitor side
    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) answers_due = {answers_due, spline_answer(on_bus)};
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[63:0], 0);
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata[31:0] !== want.px)
                        report_mismatch("pos_x", m_tdata[31:0], want.px);
                    if (m_tdata[63:32] !== want.py)
                        report_mismatch("pos_y", m_tdata[63:32], want.py);
                    if (m_tdata[95:64] !== want.dx)
                        report_mismatch("deriv_x", m_tdata[95:64], want.dx);
                    if (m_tdata[127:96] !== want.dy)
                        report_mismatch("deriv_y", m_tdata[127:96], want.dy);
                    if (m_tdata[145:128] !== want.head)
                        report_mismatch("heading", m_tdata[145:128], want.head);
                    if (m_tdata[176:146] !== want.curv)
                        report_mismatch("curvature", m_tdata[176:146], want.curv);
                    if (m_tdata[183:177] !== 7'd0)
                        report_mismatch("pad", m_tdata[183:177], 0);
                    if (m_tuser[0] !== want.oor)
                        report_mismatch("out_of_range", m_tuser[0], want.oor);
                    if (m_tuser[1] !== want.degen)
                        report_mismatch("degenerate", m_tuser[1], want.degen);
                end
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_arc_length_spline_evaluator_unit: done, errors");
            $finish;
        end
    end

    // -------------------------------------------------------------- stimulus
    task automatic push_write(int seg, int wsel, logic [31:0] val);
        beat_t it;
        it = '{cmd: CMD_WRITE, seg: seg[6:0], wsel: wsel[3:0], wval: val, arc: $urandom};
        send_queue = {send_queue, it};
    endtask

    task automatic push_query(logic [31:0] arc);
        beat_t it;
        it = '{cmd: CMD_QUERY, seg: 7'($urandom), wsel: 4'($urandom), wval: $urandom,
               arc: arc};
        send_queue = {send_queue, it};
    endtask

    // wait for every beat to go out and every answer to come back
    task automatic drain();
        wait (send_queue.size() == 0 && answers_due.size() == 0 && !s_tvalid);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_segments(int v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[6:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        seg_count = v;
    endtask

    function automatic logic [31:0] small_coef();
        return $urandom_range(3) == 0 ? $urandom
                                      : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    // mostly in-table arc lengths, sometimes anywhere
    task automatic random_phase(int count);
        int  n, seg, wsel;
        longint lo, hi;
        for (int i = 0; i < count; i++) begin
            n  = seg_count < 1 ? 1 : (seg_count > MAX_SEGMENTS ? MAX_SEGMENTS : seg_count);
            lo = start_tab[0] - Q_ONE;
            hi = start_tab[n] + Q_ONE;
            case ($urandom_range(9))
                0, 1: begin
                    seg  = $urandom_range(127);
                    wsel = $urandom_range(15);
                    // leave the parked starts and the end breakpoint alone
                    if (wsel == WSEL_START && seg > USED_SEGS && seg <= MAX_SEGMENTS)
                        seg = $urandom_range(USED_SEGS);
                    push_write(seg, wsel, small_coef());
                end
                2:    push_write($urandom_range(MAX_SEGMENTS - 1),
                                 $urandom_range(WSEL_X_C0, WSEL_Y_C3), small_coef());
                3:    push_query($urandom);
                default: begin
                    if (hi > lo) push_query(32'(lo + longint'($urandom_range(0, 32'(hi - lo)))));
                    else         push_query(32'(lo));
                end
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_segments(4);

        // ascending starts for the live segments; park the rest at the top so
        // that no query can select them, end breakpoint below the parked ones
        for (int i = 0; i <= MAX_SEGMENTS; i++) begin
            if (i <= USED_SEGS)
                push_write(i, WSEL_START, 32'(longint'(i) * 2 * Q_ONE - Q_ONE));
            else if (i == MAX_SEGMENTS)
                push_write(i, WSEL_START, 32'(20 * Q_ONE));
            else
                push_write(i, WSEL_START, 32'h7FFF_FFFF);
        end
        for (int i = 0; i <= USED_SEGS; i++)
            for (int w = WSEL_X_C0; w <= WSEL_Y_C3; w++)
                push_write(i, w, i == 0 ? 32'd0 : small_coef());
        drain();

        // directed: segment 0 is flat, so its slope is set by y c1 alone
        push_write(0, WSEL_Y_C0 + 1, 32'(Q_ONE));          // vertical, pointing up
        push_query(32'(-Q_ONE / 2));
        push_write(0, WSEL_Y_C0 + 1, 32'(-Q_ONE));         // vertical, pointing down
        push_query(32'(-Q_ONE / 2));
        push_write(0, WSEL_Y_C0 + 1, 32'd0);               // zero slope
        push_query(32'(-Q_ONE / 4));
        push_query(32'h8000_0000);                         // below the first start
        push_query(32'h7FFF_FFFF);                         // past the end breakpoint
        push_query(32'(3 * Q_ONE));                        // exactly on a start
        push_query(32'(4 * Q_ONE));
        push_write(MAX_SEGMENTS, WSEL_X_C0, $urandom);     // bad: coef of end breakpoint
        push_write(127, WSEL_START, $urandom);             // bad: start index
        push_write(5, 15, $urandom);                       // bad: word select
        push_write(2, WSEL_X_C3, 32'h7FFF_FFFF);           // steep cubic, saturates
        push_write(2, WSEL_Y_C3, 32'h8000_0000);
        push_query(32'(4 * Q_ONE - 1));
        push_query(32'(6 * Q_ONE + 12345));
        push_write(MAX_SEGMENTS, WSEL_START, 32'hFFFF_FFFF);
        push_query(32'(Q_ONE * 200));
        drain();

        // sweep the segment count through its extremes
        set_segments(0);
        random_phase(40);
        drain();
        set_segments(MAX_SEGMENTS);
        push_write(MAX_SEGMENTS, WSEL_START, 32'(130 * Q_ONE));
        random_phase(50);
        drain();
        set_segments(127);
        calm = 1'b1;                                       // no idling in this stretch
        random_phase(45);
        drain();
        calm = 1'b0;
        set_segments(1);
        random_phase(40);
        drain();

        // output held off while the input keeps offering beats
        set_segments($urandom_range(2, USED_SEGS));
        @(posedge aclk);
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        random_phase(60);
        drain();
        set_segments($urandom_range(1, USED_SEGS));
        random_phase(60);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_arc_length_spline_evaluator_unit: done, clean");
        end else begin
            $display("tb_arc_length_spline_evaluator_unit: done, errors");
        end
        $finish;
    end

endmodule
